@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the ray/sphere intersection RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSI_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSI_ASSERT(label, prop, msg)
`define RSI_ASSERT_RST(label, prop, msg)
`endif
`endif

@@ rtl/core/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Types, constants and register codes of the ray/sphere intersection unit.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PADDR_BITS  = 4;
    localparam int ROOT_STEPS  = 49;
    localparam int RAD_BITS    = 2 * ROOT_STEPS;
    localparam int REM_BITS    = ROOT_STEPS + 3;
    localparam int QUOT_STEPS  = WORD_BITS - 1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-2:0]        uword_t;
    typedef logic [47:0]                 coef_a_t;
    typedef logic signed [49:0]          coef_h_t;
    typedef logic signed [50:0]          coef_c_t;
    typedef logic signed [99:0]          wide_t;
    typedef logic [ROOT_STEPS-1:0]       root_t;
    typedef logic [50:0]                 num_t;

    localparam word_t  WORD_MAX     = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam word_t  WORD_MIN     = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
    localparam uword_t RADIUS_RESET = uword_t'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_RADIUS
    } reg_idx_t;

    typedef struct packed {
        word_t [2:0] center;
        uword_t      radius;
    } cfg_t;

    typedef struct packed {
        word_t [2:0] org;
        word_t [2:0] dir;
    } ray_t;

    typedef struct packed {
        logic    miss;
        coef_a_t a;
        coef_h_t h;
        ray_t    ray;
    } root_side_t;

    typedef struct packed {
        logic    miss;
        coef_a_t a;
        logic    sat;
        ray_t    ray;
    } dist_side_t;

    typedef struct packed {
        logic        miss;
        uword_t      t;
        word_t [2:0] pnt;
        logic [2:0]  neg;
        logic [2:0]  sat;
    } norm_side_t;

    typedef struct packed {
        logic        found;
        uword_t      distance;
        word_t [2:0] pnt;
        word_t [2:0] nrm;
    } hit_res_t;

endpackage

@@ rtl/core/rsi_ray_if.sv @@
// ----------------------------------------------------------------------------
// rsi_ray_if
// Ray request channel: origin and direction with valid/ready.
// ----------------------------------------------------------------------------
interface rsi_ray_if
    import rsi_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t origin_x;
    word_t origin_y;
    word_t origin_z;
    word_t dir_x;
    word_t dir_y;
    word_t dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

@@ rtl/core/rsi_hit_if.sv @@
// ----------------------------------------------------------------------------
// rsi_hit_if
// Hit result channel: flag, distance, point and normal with valid/ready.
// ----------------------------------------------------------------------------
interface rsi_hit_if
    import rsi_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   hit_found;
    uword_t hit_distance;
    word_t  point_x;
    word_t  point_y;
    word_t  point_z;
    word_t  normal_x;
    word_t  normal_y;
    word_t  normal_z;

    modport source (output valid, hit_found, hit_distance, point_x, point_y, point_z,
                    normal_x, normal_y, normal_z, input ready);
    modport sink   (input valid, hit_found, hit_distance, point_x, point_y, point_z,
                    normal_x, normal_y, normal_z, output ready);
endinterface

@@ rtl/core/ray_sphere_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray against configured sphere: hit flag, distance, point and unit normal.
// ----------------------------------------------------------------------------
// One ray enters per clock when the pipeline is not held: 6 stages
// form the quadratic coefficients and discriminant, 49 stages take the square
// root one bit each, 2 pick the nearer positive root, 31 stages divide for the
// distance one quotient bit each, 4 form the hit point and its offset from the
// centre, 31 divide the three normal lanes by the radius and one holds the
// result. The whole pipeline holds while a result waits on the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_sphere_intersect
    import rsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rsi_ray_if.sink               ray,
    rsi_hit_if.source             hit,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t             cfg;
    ray_t             ray_pl;
    logic             en;
    logic             su_valid, rt_valid, ds_valid, nm_valid;
    root_side_t       su_side;
    wide_t            su_disc;
    dist_side_t       rt_side;
    num_t             rt_num;
    norm_side_t       ds_side;
    logic [2:0][31:0] ds_mag;
    hit_res_t         res;

    assign en        = !nm_valid || hit.ready;
    assign ray.ready = en;

    assign ray_pl.org = {ray.origin_z, ray.origin_y, ray.origin_x};
    assign ray_pl.dir = {ray.dir_z, ray.dir_y, ray.dir_x};

    rsi_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsi_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ray.valid),
        .ray_in    (ray_pl),
        .cfg       (cfg),
        .out_valid (su_valid),
        .side_out  (su_side),
        .disc_out  (su_disc)
    );

    rsi_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (su_valid),
        .side_in   (su_side),
        .disc_in   (su_disc),
        .out_valid (rt_valid),
        .side_out  (rt_side),
        .num_out   (rt_num)
    );

    rsi_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .side_in   (rt_side),
        .num_in    (rt_num),
        .cfg       (cfg),
        .out_valid (ds_valid),
        .side_out  (ds_side),
        .mag_out   (ds_mag)
    );

    rsi_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ds_valid),
        .side_in   (ds_side),
        .mag_in    (ds_mag),
        .cfg       (cfg),
        .out_valid (nm_valid),
        .res_out   (res)
    );

    assign hit.valid        = nm_valid;
    assign hit.hit_found    = res.found;
    assign hit.hit_distance = res.distance;
    assign hit.point_x      = res.pnt[0];
    assign hit.point_y      = res.pnt[1];
    assign hit.point_z      = res.pnt[2];
    assign hit.normal_x     = res.nrm[0];
    assign hit.normal_y     = res.nrm[1];
    assign hit.normal_z     = res.nrm[2];

    `RSI_ASSERT(a_miss_zero, (hit.valid && !hit.hit_found) |-> (hit.hit_distance == 0 && hit.point_x == 0 && hit.normal_x == 0), "miss result carries nonzero fields")
    `RSI_ASSERT(a_hit_dist, (hit.valid && hit.hit_found) |-> (hit.hit_distance != 0), "hit reported at zero distance")
    `RSI_ASSERT(a_stall_hold, (hit.valid && !hit.ready) |-> !ray.ready, "request taken while pipeline stalled")
    `RSI_ASSERT_RST(a_rst_idle, !rst_n |=> !hit.valid, "result valid after reset")

endmodule

@@ rtl/core/rsi_cfg.sv @@
// ----------------------------------------------------------------------------
// rsi_cfg
// APB register file holding the sphere centre and radius.
// ----------------------------------------------------------------------------
module rsi_cfg
    import rsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    word_t    cx_reg;
    word_t    cy_reg;
    word_t    cz_reg;
    uword_t   radius_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= RADIUS_RESET;
        end
        else if (wr)
        begin
            case (idx)
                REG_CENTER_X: cx_reg     <= word_t'(pwdata);
                REG_CENTER_Y: cy_reg     <= word_t'(pwdata);
                REG_CENTER_Z: cz_reg     <= word_t'(pwdata);
                REG_RADIUS:   radius_reg <= pwdata[WORD_BITS-2:0];
                default:      cx_reg     <= cx_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CENTER_X: prdata = cx_reg;
            REG_CENTER_Y: prdata = cy_reg;
            REG_CENTER_Z: prdata = cz_reg;
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            default:      prdata = '0;
        endcase
    end

    // zero radius acts as one LSB
    assign cfg.center = {cz_reg, cy_reg, cx_reg};
    assign cfg.radius = (radius_reg == '0) ? uword_t'(1) : radius_reg;

endmodule

@@ rtl/core/rsi_setup.sv @@
// ----------------------------------------------------------------------------
// rsi_setup
// Quadratic coefficients a, h, c and the discriminant h*h - a*c, six stages.
// ----------------------------------------------------------------------------
module rsi_setup
    import rsi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  ray_t       ray_in,
    input  cfg_t       cfg,
    output logic       out_valid,
    output root_side_t side_out,
    output wide_t      disc_out
);

    logic [5:0] v_reg;

    logic signed [32:0] l1_reg [3];
    ray_t               ray1_reg;

    logic signed [63:0] dd2_reg [3];
    logic signed [64:0] ld2_reg [3];
    logic signed [65:0] ll2_reg [3];
    logic [61:0]        rr2_reg;
    ray_t               ray2_reg;

    coef_a_t a3_reg;
    coef_h_t h3_reg;
    coef_c_t c3_reg;
    ray_t    ray3_reg;

    logic signed [53:0] phh4_reg, phl4_reg, pll4_reg;
    logic signed [53:0] qhh4_reg, qhl4_reg, qlh4_reg, qll4_reg;
    root_side_t         sd4_reg;

    wide_t      hh5_reg;
    wide_t      ac5_reg;
    root_side_t sd5_reg;

    wide_t      disc6_reg;
    root_side_t sd6_reg;

    logic signed [50:0] a_sum;
    logic signed [50:0] h_sum;
    logic signed [51:0] c_sum;
    logic signed [26:0] h_hi, h_lo, a_hi, a_lo, c_hi, c_lo;
    wide_t              hh_next, ac_next, disc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_comb
    begin
        a_sum = 51'(dd2_reg[0] >>> FRAC_BITS) + 51'(dd2_reg[1] >>> FRAC_BITS)
              + 51'(dd2_reg[2] >>> FRAC_BITS);
        h_sum = 51'(ld2_reg[0] >>> FRAC_BITS) + 51'(ld2_reg[1] >>> FRAC_BITS)
              + 51'(ld2_reg[2] >>> FRAC_BITS);
        c_sum = 52'(ll2_reg[0] >>> FRAC_BITS) + 52'(ll2_reg[1] >>> FRAC_BITS)
              + 52'(ll2_reg[2] >>> FRAC_BITS) - $signed(52'(rr2_reg >> FRAC_BITS));
    end

    assign h_hi = 27'($signed(h3_reg[49:25]));
    assign h_lo = $signed({2'b00, h3_reg[24:0]});
    assign a_hi = $signed({3'b000, a3_reg[47:24]});
    assign a_lo = $signed({3'b000, a3_reg[23:0]});
    assign c_hi = 27'($signed(c3_reg[50:26]));
    assign c_lo = $signed({1'b0, c3_reg[25:0]});

    assign hh_next = (wide_t'(phh4_reg) <<< 50) + (wide_t'(phl4_reg) <<< 26)
                   + wide_t'(pll4_reg);
    assign ac_next = (wide_t'(qhh4_reg) <<< 50) + (wide_t'(qhl4_reg) <<< 24)
                   + (wide_t'(qlh4_reg) <<< 26) + wide_t'(qll4_reg);
    assign disc_next = hh5_reg - ac5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                l1_reg[i]  <= 33'($signed(ray_in.org[i])) - 33'($signed(cfg.center[i]));
                dd2_reg[i] <= $signed(ray1_reg.dir[i]) * $signed(ray1_reg.dir[i]);
                ld2_reg[i] <= l1_reg[i] * $signed(ray1_reg.dir[i]);
                ll2_reg[i] <= l1_reg[i] * l1_reg[i];
            end
            ray1_reg <= ray_in;
            rr2_reg  <= cfg.radius * cfg.radius;
            ray2_reg <= ray1_reg;

            a3_reg   <= a_sum[47:0];
            h3_reg   <= h_sum[49:0];
            c3_reg   <= c_sum[50:0];
            ray3_reg <= ray2_reg;

            phh4_reg     <= h_hi * h_hi;
            phl4_reg     <= h_hi * h_lo;
            pll4_reg     <= h_lo * h_lo;
            qhh4_reg     <= a_hi * c_hi;
            qhl4_reg     <= a_hi * c_lo;
            qlh4_reg     <= a_lo * c_hi;
            qll4_reg     <= a_lo * c_lo;
            sd4_reg.miss <= (a3_reg == '0);
            sd4_reg.a    <= a3_reg;
            sd4_reg.h    <= h3_reg;
            sd4_reg.ray  <= ray3_reg;

            hh5_reg <= hh_next;
            ac5_reg <= ac_next;
            sd5_reg <= sd4_reg;

            disc6_reg <= disc_next;
            sd6_reg   <= {sd5_reg.miss | disc_next[99], sd5_reg.a, sd5_reg.h, sd5_reg.ray};
        end
    end

    assign out_valid = v_reg[5];
    assign side_out  = sd6_reg;
    assign disc_out  = disc6_reg;

endmodule

@@ rtl/core/rsi_root.sv @@
// ----------------------------------------------------------------------------
// rsi_root
// Pipelined square root, one root bit per stage, then root selection.
// ----------------------------------------------------------------------------
module rsi_root
    import rsi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  root_side_t side_in,
    input  wide_t      disc_in,
    output logic       out_valid,
    output dist_side_t side_out,
    output num_t       num_out
);

    logic [ROOT_STEPS-1:0] v_reg;
    logic [RAD_BITS-1:0]   rad_reg  [ROOT_STEPS];
    logic [REM_BITS-1:0]   rem_reg  [ROOT_STEPS];
    root_t                 root_reg [ROOT_STEPS];
    root_side_t            sd_reg   [ROOT_STEPS];

    logic               vn1_reg, vn2_reg;
    logic signed [51:0] n1_reg, n2_reg;
    root_side_t         sdn1_reg;
    dist_side_t         sdn2_reg;
    num_t               num_reg;

    logic               ok1, ok2, sat;
    logic signed [51:0] num_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            vn1_reg <= 1'b0;
            vn2_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg   <= {v_reg[ROOT_STEPS-2:0], in_valid};
            vn1_reg <= v_reg[ROOT_STEPS-1];
            vn2_reg <= vn1_reg;
        end
    end

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_step
        logic [RAD_BITS-1:0] rad_in;
        logic [REM_BITS-1:0] rem_in;
        logic [REM_BITS-1:0] rem_shift;
        logic [REM_BITS-1:0] trial;
        root_t               root_in;
        root_side_t          sd_in;
        logic                ge;

        if (k == 0)
        begin : g_first
            assign rad_in  = disc_in[RAD_BITS-1:0];
            assign rem_in  = '0;
            assign root_in = '0;
            assign sd_in   = side_in;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sd_in   = sd_reg[k-1];
        end

        assign rem_shift = {rem_in[REM_BITS-3:0], rad_in[RAD_BITS-1 -: 2]};
        assign trial     = {1'b0, root_in, 2'b01};
        assign ge        = (rem_shift >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= ge ? rem_shift - trial : rem_shift;
                root_reg[k] <= {root_in[ROOT_STEPS-2:0], ge};
                sd_reg[k]   <= sd_in;
            end
        end
    end

    // a root counts as positive only once its quotient rounds to at least one LSB
    always_comb
    begin
        ok1     = !n1_reg[51] && ({n1_reg, 16'b0} >= 68'(sdn1_reg.a));
        ok2     = !n2_reg[51] && ({n2_reg, 16'b0} >= 68'(sdn1_reg.a));
        num_sel = ok2 ? n2_reg : n1_reg;
        sat     = (63'(num_sel[50:0]) >= {sdn1_reg.a, 15'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= $signed({3'b000, root_reg[ROOT_STEPS-1]})
                      - 52'(sd_reg[ROOT_STEPS-1].h);
            n2_reg   <= -52'(sd_reg[ROOT_STEPS-1].h)
                      - $signed({3'b000, root_reg[ROOT_STEPS-1]});
            sdn1_reg <= sd_reg[ROOT_STEPS-1];

            sdn2_reg.miss <= sdn1_reg.miss | !ok1;
            sdn2_reg.a    <= sdn1_reg.a;
            sdn2_reg.sat  <= sat;
            sdn2_reg.ray  <= sdn1_reg.ray;
            num_reg       <= num_sel[50:0];
        end
    end

    assign out_valid = vn2_reg;
    assign side_out  = sdn2_reg;
    assign num_out   = num_reg;

endmodule

@@ rtl/core/rsi_dist.sv @@
// ----------------------------------------------------------------------------
// rsi_dist
// Distance divider (one quotient bit per stage), hit point and centre offset.
// ----------------------------------------------------------------------------
module rsi_dist
    import rsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  dist_side_t        side_in,
    input  num_t              num_in,
    input  cfg_t              cfg,
    output logic              out_valid,
    output norm_side_t        side_out,
    output logic [2:0][31:0]  mag_out
);

    logic [QUOT_STEPS-1:0] v_reg;
    logic [48:0]           rem_reg [QUOT_STEPS];
    logic [QUOT_STEPS-1:0] lo_reg  [QUOT_STEPS];
    dist_side_t            sd_reg  [QUOT_STEPS];

    logic [3:0]         vt_reg;
    uword_t             t_reg, tp1_reg, tp2_reg;
    ray_t               rayt_reg, rayp1_reg;
    logic [2:0]         miss_reg;
    logic signed [63:0] prod_reg [3];
    word_t [2:0]        pnt_reg;
    norm_side_t         sdo_reg;
    logic [2:0][31:0]   mag_reg;

    logic signed [48:0] psum [3];
    word_t [2:0]        pnt_next;
    logic signed [32:0] diff [3];
    logic signed [32:0] mag33 [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vt_reg <= '0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[QUOT_STEPS-2:0], in_valid};
            vt_reg <= {vt_reg[2:0], v_reg[QUOT_STEPS-1]};
        end
    end

    for (genvar k = 0; k < QUOT_STEPS; k++)
    begin : g_step
        logic [48:0]           rem_in;
        logic [48:0]           rs;
        logic [48:0]           dv;
        logic [QUOT_STEPS-1:0] lo_in;
        dist_side_t            sd_in;
        logic                  ge;

        if (k == 0)
        begin : g_first
            assign rem_in = 49'(num_in[50:15]);
            assign lo_in  = {num_in[14:0], 16'b0};
            assign sd_in  = side_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign sd_in  = sd_reg[k-1];
        end

        assign rs = {rem_in[47:0], lo_in[QUOT_STEPS-1]};
        assign dv = {1'b0, sd_in.a};
        assign ge = (rs >= dv);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? rs - dv : rs;
                lo_reg[k]  <= {lo_in[QUOT_STEPS-2:0], ge};
                sd_reg[k]  <= sd_in;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            psum[i] = 49'($signed(rayp1_reg.org[i])) + 49'(prod_reg[i] >>> FRAC_BITS);
            if (psum[i][48] && !(&psum[i][47:31]))
            begin
                pnt_next[i] = WORD_MIN;
            end
            else if (!psum[i][48] && (|psum[i][47:31]))
            begin
                pnt_next[i] = WORD_MAX;
            end
            else
            begin
                pnt_next[i] = psum[i][31:0];
            end
            diff[i]  = 33'($signed(pnt_reg[i])) - 33'($signed(cfg.center[i]));
            mag33[i] = diff[i][32] ? -diff[i] : diff[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg       <= sd_reg[QUOT_STEPS-1].sat ? uword_t'(WORD_MAX)
                                                    : lo_reg[QUOT_STEPS-1];
            rayt_reg    <= sd_reg[QUOT_STEPS-1].ray;
            miss_reg[0] <= sd_reg[QUOT_STEPS-1].miss;

            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= $signed(rayt_reg.dir[i]) * $signed({1'b0, t_reg});
            end
            tp1_reg     <= t_reg;
            rayp1_reg   <= rayt_reg;
            miss_reg[1] <= miss_reg[0];

            pnt_reg     <= pnt_next;
            tp2_reg     <= tp1_reg;
            miss_reg[2] <= miss_reg[1];

            sdo_reg.miss <= miss_reg[2];
            sdo_reg.t    <= tp2_reg;
            sdo_reg.pnt  <= pnt_reg;
            for (int i = 0; i < 3; i++)
            begin
                sdo_reg.neg[i] <= diff[i][32];
                sdo_reg.sat[i] <= (47'(mag33[i][31:0]) >= {cfg.radius, 15'b0});
                mag_reg[i]     <= mag33[i][31:0];
            end
        end
    end

    assign out_valid = vt_reg[3];
    assign side_out  = sdo_reg;
    assign mag_out   = mag_reg;

endmodule

@@ rtl/core/rsi_norm.sv @@
// ----------------------------------------------------------------------------
// rsi_norm
// Three-lane normal divider by the radius and the result register.
// ----------------------------------------------------------------------------
module rsi_norm
    import rsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  norm_side_t       side_in,
    input  logic [2:0][31:0] mag_in,
    input  cfg_t             cfg,
    output logic             out_valid,
    output hit_res_t         res_out
);

    logic [QUOT_STEPS-1:0] v_reg;
    logic [31:0]           rem_reg [QUOT_STEPS][3];
    logic [QUOT_STEPS-1:0] lo_reg  [QUOT_STEPS][3];
    norm_side_t            sd_reg  [QUOT_STEPS];

    logic     out_valid_reg;
    hit_res_t res_reg;
    hit_res_t res_next;
    word_t    q32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[QUOT_STEPS-2:0], in_valid};
            out_valid_reg <= v_reg[QUOT_STEPS-1];
        end
    end

    for (genvar k = 0; k < QUOT_STEPS; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sd_reg[k] <= side_in;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sd_reg[k] <= sd_reg[k-1];
                end
            end
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            logic [31:0]           rem_in;
            logic [31:0]           rs;
            logic [31:0]           dv;
            logic [QUOT_STEPS-1:0] lo_in;
            logic                  ge;

            if (k == 0)
            begin : g_first
                assign rem_in = 32'(mag_in[j][31:15]);
                assign lo_in  = {mag_in[j][14:0], 16'b0};
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1][j];
                assign lo_in  = lo_reg[k-1][j];
            end

            assign rs = {rem_in[30:0], lo_in[QUOT_STEPS-1]};
            assign dv = {1'b0, cfg.radius};
            assign ge = (rs >= dv);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k][j] <= ge ? rs - dv : rs;
                    lo_reg[k][j]  <= {lo_in[QUOT_STEPS-2:0], ge};
                end
            end
        end
    end

    // drop every field on a miss
    always_comb
    begin
        res_next.found    = !sd_reg[QUOT_STEPS-1].miss;
        res_next.distance = sd_reg[QUOT_STEPS-1].t;
        res_next.pnt      = sd_reg[QUOT_STEPS-1].pnt;
        q32               = '0;
        for (int j = 0; j < 3; j++)
        begin
            q32 = word_t'({1'b0, lo_reg[QUOT_STEPS-1][j]});
            if (sd_reg[QUOT_STEPS-1].sat[j])
            begin
                res_next.nrm[j] = sd_reg[QUOT_STEPS-1].neg[j] ? WORD_MIN : WORD_MAX;
            end
            else
            begin
                res_next.nrm[j] = sd_reg[QUOT_STEPS-1].neg[j] ? -q32 : q32;
            end
        end
        if (sd_reg[QUOT_STEPS-1].miss)
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_out   = res_reg;

endmodule

@@ tb/tb_ray_sphere_intersect.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect
// Streams rays through the intersection unit under several sphere settings,
// with random stalls on both channels, and checks every hit result against a
// listed result or a fixed-point model of the quadratic solve in this bench.
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect;
    import rsi_pkg::*;

    localparam logic signed [127:0] L64_MAX = 128'sd9223372036854775807;
    localparam logic signed [127:0] L64_MIN = -L64_MAX - 1;
    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;
    localparam int     ONE = 1 << FRAC_BITS;

    typedef struct {
        ray_t     ray;
        bit       typed;
        hit_res_t res;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    rsi_ray_if ray_ch();
    rsi_hit_if hit_ch();

    ray_sphere_intersect dut (
        .clk(clk), .rst_n(rst_n), .ray(ray_ch), .hit(hit_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    longint   sph_center [3];
    longint   sph_radius;
    hit_res_t hits_due [$];
    bit       calm;
    bit       row_typed;
    hit_res_t row_res;
    int       errors;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint clip64(logic signed [127:0] w);
        if (w > L64_MAX) return L64_MAX[63:0];
        if (w < L64_MIN) return L64_MIN[63:0];
        return w[63:0];
    endfunction

    function automatic longint add_sat(longint x, longint y);
        logic signed [127:0] xw = x;
        logic signed [127:0] yw = y;
        return clip64(xw + yw);
    endfunction

    function automatic longint sub_sat(longint x, longint y);
        logic signed [127:0] xw = x;
        logic signed [127:0] yw = y;
        return clip64(xw - yw);
    endfunction

    function automatic longint fx_mul(longint x, longint y);
        logic signed [127:0] xw = x;
        logic signed [127:0] yw = y;
        logic signed [127:0] p;
        p = xw * yw;
        return clip64(p >>> FRAC_BITS);
    endfunction

    function automatic longint fx_div(longint num, longint den);
        logic signed [127:0] nw = num;
        logic [127:0] mag;
        logic [127:0] dw;
        logic [127:0] q;
        mag = (num < 0) ? -nw : nw;
        dw = den;
        q = (mag << FRAC_BITS) / dw;
        if (q >= (128'd1 << 63)) return (num < 0) ? L64_MIN[63:0] : L64_MAX[63:0];
        return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [63:0]  res;
        logic [127:0] cw;
        res = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cw = res | (64'd1 << i);
            if (cw * cw <= n) res = cw[63:0];
        end
        return res;
    endfunction

    function automatic longint clip_word(longint x);
        if (x > W_MAX) return W_MAX;
        if (x < W_MIN) return W_MIN;
        return x;
    endfunction

    function automatic hit_res_t trace_sphere(ray_t r);
        hit_res_t res;
        longint o [3], d [3], l [3], p [3];
        longint rr, a, h, cc, s, t1, t2, t;
        logic signed [127:0] hw, aw, cw, sw, disc;
        logic [63:0] root;
        res = '0;
        a = 0;
        h = 0;
        cc = 0;
        rr = (sph_radius == 0) ? 1 : sph_radius;
        for (int i = 0; i < 3; i++)
        begin
            o[i] = longint'(r.org[i]);
            d[i] = longint'(r.dir[i]);
            l[i] = sub_sat(o[i], sph_center[i]);
            a = add_sat(a, fx_mul(d[i], d[i]));
            h = add_sat(h, fx_mul(l[i], d[i]));
            cc = add_sat(cc, fx_mul(l[i], l[i]));
        end
        cc = sub_sat(cc, fx_mul(rr, rr));
        if (a <= 0) return res;
        hw = h;
        aw = a;
        cw = cc;
        disc = hw * hw - aw * cw;
        if (disc < 0) return res;
        root = floor_root(disc);
        s = root[63] ? L64_MAX[63:0] : longint'(root);
        sw = s;
        t1 = fx_div(clip64(-hw + sw), a);
        if (t1 <= 0) return res;
        t2 = fx_div(clip64(-hw - sw), a);
        t = (t2 > 0) ? t2 : t1;
        if (t > W_MAX) t = W_MAX;
        res.found = 1'b1;
        res.distance = uword_t'(t);
        for (int i = 0; i < 3; i++)
        begin
            p[i] = clip_word(add_sat(o[i], fx_mul(d[i], t)));
            res.pnt[i] = word_t'(p[i]);
            res.nrm[i] = word_t'(clip_word(fx_div(sub_sat(p[i], sph_center[i]), rr)));
        end
        return res;
    endfunction

    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_BITS'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_RADIUS) sph_radius = value[30:0];
        else sph_center[idx] = longint'($signed(value));
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad);
        while (hits_due.size() != 0) @(posedge clk);
        repeat (130) @(posedge clk);
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
        reg_write(REG_CENTER_Z, cz);
        reg_write(REG_RADIUS, rad);
    endtask

    task automatic send_ray(ray_t r, bit typed, hit_res_t res);
        while (!calm && $urandom_range(0, 99) < 25)
        begin
            ray_ch.valid <= 1'b0;
            @(negedge clk);
        end
        ray_ch.origin_x <= r.org[0];
        ray_ch.origin_y <= r.org[1];
        ray_ch.origin_z <= r.org[2];
        ray_ch.dir_x <= r.dir[0];
        ray_ch.dir_y <= r.dir[1];
        ray_ch.dir_z <= r.dir[2];
        row_typed <= typed;
        row_res <= res;
        ray_ch.valid <= 1'b1;
        @(posedge clk);
        while (!ray_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 3))
            0: return word_t'($urandom());
            1: return word_t'($signed($urandom_range(0, 32 * ONE)) - 16 * ONE);
            2: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            default: return word_t'($signed($urandom_range(0, 4 * ONE)) - 2 * ONE);
        endcase
    endfunction

    function automatic ray_t aimed_ray();
        ray_t r;
        longint off, scale;
        scale = $urandom_range(1, 8);
        for (int i = 0; i < 3; i++)
        begin
            off = longint'($urandom_range(0, 40 * ONE)) - 20 * ONE;
            r.org[i] = word_t'(clip_word(sph_center[i] + off));
            r.dir[i] = word_t'(clip_word((sph_center[i] - longint'(r.org[i])
                       + longint'($urandom_range(0, ONE)) - ONE / 2) * scale / 4));
        end
        return r;
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        if ($urandom_range(0, 99) < 65) return aimed_ray();
        for (int i = 0; i < 3; i++)
        begin
            r.org[i] = rand_word();
            r.dir[i] = rand_word();
        end
        return r;
    endfunction

    function automatic bit check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n) hit_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin
        ray_t     r;
        hit_res_t w;
        bit       bad;
        if (rst_n && ray_ch.valid && ray_ch.ready)
        begin
            r.org[0] = ray_ch.origin_x;
            r.org[1] = ray_ch.origin_y;
            r.org[2] = ray_ch.origin_z;
            r.dir[0] = ray_ch.dir_x;
            r.dir[1] = ray_ch.dir_y;
            r.dir[2] = ray_ch.dir_z;
            hits_due = {hits_due, (row_typed ? row_res : trace_sphere(r))};
        end
        if (rst_n && hit_ch.valid && hit_ch.ready)
        begin
            if (hits_due.size() == 0)
            begin
                $error("hit result with no request outstanding");
                errors++;
            end
            else
            begin
                w = hits_due.pop_front();
                bad = 1'b0;
                bad |= check_field("hit_found", w.found, hit_ch.hit_found);
                bad |= check_field("hit_distance", w.distance, hit_ch.hit_distance);
                bad |= check_field("point_x", w.pnt[0], hit_ch.point_x);
                bad |= check_field("point_y", w.pnt[1], hit_ch.point_y);
                bad |= check_field("point_z", w.pnt[2], hit_ch.point_z);
                bad |= check_field("normal_x", w.nrm[0], hit_ch.normal_x);
                bad |= check_field("normal_y", w.nrm[1], hit_ch.normal_y);
                bad |= check_field("normal_z", w.nrm[2], hit_ch.normal_z);
                if (bad) errors++;
            end
        end
    end

    initial
    begin
        row_t     rows [$];
        row_t     rw;
        hit_res_t none;
        int       wait_cycles;
        errors = 0;
        calm = 1'b0;
        none = '0;
        sph_center = '{0, 0, 0};
        sph_radius = ONE;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = '0;
        ray_ch.origin_y = '0;
        ray_ch.origin_z = '0;
        ray_ch.dir_x = '0;
        ray_ch.dir_y = '0;
        ray_ch.dir_z = '0;
        hit_ch.ready = 1'b0;
        row_typed = 1'b0;
        row_res = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero-length direction misses
        rw.ray = '0;
        rw.typed = 1'b1;
        rw.res = none;
        rows = {rows, rw};
        // straight hit on the unit sphere from x = -5
        rw.ray.org = '{0, 0, -5 * ONE};
        rw.ray.dir = '{0, 0, ONE};
        rw.res.found = 1'b1;
        rw.res.distance = 4 * ONE;
        rw.res.pnt = '{0, 0, -ONE};
        rw.res.nrm = '{0, 0, -ONE};
        rows = {rows, rw};
        // pointing away: larger root negative
        rw.ray.dir = '{0, 0, -ONE};
        rw.res = none;
        rows = {rows, rw};
        // short direction rounds a to zero
        rw.ray.dir = '{0, 1, 1};
        rows = {rows, rw};
        rw.typed = 1'b0;
        // origin inside: nearer root negative
        rw.ray.org = '{0, 0, 0};
        rw.ray.dir = '{ONE, 0, 0};
        rows = {rows, rw};
        // ray that passes beside the sphere and misses
        rw.ray.org = '{-5 * ONE, ONE, 0};
        rw.ray.dir = '{0, 0, ONE};
        rows = {rows, rw};
        rw.ray.org = '{WORD_MAX, WORD_MAX, WORD_MAX};
        rw.ray.dir = '{WORD_MIN, WORD_MIN, WORD_MIN};
        rows = {rows, rw};
        rw.ray.org = '{WORD_MIN, WORD_MIN, WORD_MIN};
        rw.ray.dir = '{WORD_MAX, WORD_MAX, WORD_MAX};
        rows = {rows, rw};
        rw.ray.org = '{WORD_MIN, 0, WORD_MAX};
        rw.ray.dir = '{1, -1, WORD_MIN};
        rows = {rows, rw};
        rw.ray.org = '{-3 * ONE, -3 * ONE, -3 * ONE};
        rw.ray.dir = '{1, 1, 1};
        rows = {rows, rw};
        rw.ray.org = '{-2 * ONE, 0, 0};
        rw.ray.dir = '{0, 0, 2 * ONE};
        rows = {rows, rw};
        foreach (rows[i])
        begin
            send_ray(rows[i].ray, rows[i].typed, rows[i].res);
        end
        ray_ch.valid <= 1'b0;

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_sphere(32'd0, 32'd0, 32'd0, ONE);
                1: set_sphere($urandom(), $urandom(), $urandom(), $urandom_range(1, 32 * ONE));
                2: set_sphere(WORD_MAX, WORD_MIN, 3 * ONE, 32'h7fff_ffff);
                3: set_sphere(2 * ONE, -7 * ONE, ONE / 2, 32'd0);
                4: set_sphere(WORD_MIN, WORD_MAX, 0, 32'd1);
                default: set_sphere(-ONE, ONE, 5 * ONE, 32'hffff_ffff);
            endcase
            calm = (phase == 1);
            repeat (185)
            begin
                send_ray(rand_ray(), 1'b0, none);
            end
            ray_ch.valid <= 1'b0;
            calm = 1'b0;
        end

        wait_cycles = 0;
        while (hits_due.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (130) @(posedge clk);
        if (errors == 0 && hits_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
